// ----- hdl/svt_pkg.sv -----
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants for the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int CAPACITY      = 16;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int VALUE_W       = 32;
    localparam int ENTRY_CNT_W   = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2
    } svt_mode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } svt_status_t;

    typedef struct packed {
        svt_mode_t                  mode;
        logic signed [VALUE_W-1:0]  value;
    } svt_req_t;

    typedef struct packed {
        svt_status_t                status;
        logic [ENTRY_CNT_W-1:0]     entry_count;
    } svt_rsp_t;

    typedef struct packed {
        logic                       ins_go;
        logic                       del_req;
        logic signed [VALUE_W-1:0]  value;
    } svt_cmd_t;

endpackage

// ----- hdl/svt_cell.sv -----
// ----------------------------------------------------------------------------
// svt_cell
// One slot of the sorted chain: compares against the request value and
// shifts with its neighbors on insert or delete.
// ----------------------------------------------------------------------------
module svt_cell
    import svt_pkg::*;
(
    input  logic                        clk,
    input  svt_cmd_t                    cmd,
    input  logic                        occupied,
    input  logic                        prev_lt,
    input  logic                        found,
    input  logic signed [VALUE_W-1:0]   left_entry,
    input  logic signed [VALUE_W-1:0]   right_entry,
    output logic                        lt,
    output logic                        hit,
    output logic signed [VALUE_W-1:0]   entry
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    assign lt    = occupied && (entry_reg < cmd.value);
    assign hit   = occupied && (entry_reg == cmd.value) && prev_lt;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_go && !lt)
        begin
            entry_next = prev_lt ? cmd.value : left_entry;
        end
        else if (cmd.del_req && found && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hdl/sorted_value_table.sv -----
// ----------------------------------------------------------------------------
// sorted_value_table
// The result item is registered when the request item is taken.
// Throughput: one item per cycle while results are taken; the whole cell chain settles in that cycle.
// The output register lets a new item enter while the last result is taken.
// Reset clears the entry count and the output valid; cell contents stay
// undefined until written and are never read above the count.
// ----------------------------------------------------------------------------
module sorted_value_table
    import svt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  svt_req_t    req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output svt_rsp_t    rsp
);

    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           rsp_valid_reg;
    svt_rsp_t                       rsp_reg;
    svt_rsp_t                       rsp_next;
    logic                           accept;
    logic                           empty;
    logic                           full;
    logic                           found;
    svt_status_t                    status;
    svt_cmd_t                       cmd;
    logic [CAPACITY-1:0]            lt_vec;
    logic [CAPACITY-1:0]            hit_vec;
    logic [CAPACITY-1:0]            occ_vec;
    logic signed [VALUE_W-1:0]      entries [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = |hit_vec;

    assign cmd.ins_go  = accept && (req.mode == MODE_INSERT) && !full;
    assign cmd.del_req = accept && (req.mode == MODE_DELETE);
    assign cmd.value   = req.value;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                       prev_lt;
            logic signed [VALUE_W-1:0]  left_entry;
            logic signed [VALUE_W-1:0]  right_entry;

            assign occ_vec[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign prev_lt    = 1'b1;
                assign left_entry = req.value;
            end
            else
            begin : g_mid
                assign prev_lt    = lt_vec[i-1];
                assign left_entry = entries[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_entry = entries[i];
            end
            else
            begin : g_inner
                assign right_entry = entries[i+1];
            end

            svt_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occ_vec[i]),
                .prev_lt     (prev_lt),
                .found       (found),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .lt          (lt_vec[i]),
                .hit         (hit_vec[i]),
                .entry       (entries[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        status     = ST_DONE;
        case (req.mode)
            MODE_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (found)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (!found)
                begin
                    status = ST_NOT_FOUND;
                end
            end
        endcase
        rsp_next.status      = status;
        rsp_next.entry_count = ENTRY_CNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0))
        else $error("empty status with nonzero count");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.mode == MODE_INSERT) && full |=> $stable(count_reg))
        else $error("count changed on insert into full table");

    a_delete_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.mode == MODE_DELETE) && found
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("count not decremented on delete");
`endif

endmodule
